/* rtl/shk_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the shake toggle detector.
// No dependencies; shk_sumsq, shk_isqrt, the top level and the bench import this package.
package shk_pkg;

    // Field widths fixed by the interface.
    localparam int RATE_W    = 16;
    localparam int ROOT_W    = 16;
    localparam int SUMSQ_W   = 32;
    localparam int CUTOFF_W  = 16;
    localparam int TOTAL_W   = 21;
    localparam int DIGIT_W   = 2;

    // Largest magnitude three 16-bit rates can produce.
    localparam int MAG_MAX = 56755;

    // Reported window total saturates here.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Configuration port.
    localparam int PADDR_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MOTION_CUTOFF = '0;
    localparam logic [CUTOFF_W-1:0]  CUTOFF_RESET      = 16'd20000;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } sample_t;

    typedef struct packed {
        logic [ROOT_W-1:0]  magnitude;
        logic [TOTAL_W-1:0] window_total;
        logic               high_motion;
        logic               led_on;
        logic               toggled;
    } result_t;

endpackage

/* rtl/shk_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module shk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/shk_sumsq.sv */
`timescale 1ns / 1ps
// Sum of the squared absolute rates of one sample, two multiplier bits per cycle.
// Depends on shk_pkg.
module shk_sumsq
    import shk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sample_t             sample,
    output logic [SUMSQ_W-1:0]  sum,
    output logic                done
);

    localparam int STEPS  = RATE_W / DIGIT_W;
    localparam int CNT_W  = $clog2(STEPS);
    localparam int TERM_W = RATE_W + 3;
    localparam int ACC_W  = SUMSQ_W + 1;
    localparam int AXES   = 3;

    logic [RATE_W-1:0] a_reg  [AXES];
    logic [RATE_W:0]   a3_reg [AXES];
    logic [RATE_W-1:0] m_reg  [AXES];
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RATE_W-1:0] abs_in [AXES];
    logic [TERM_W-1:0] term   [AXES];
    logic [TERM_W-1:0] digit_sum;
    logic [TERM_W-1:0] upper_sum;

    function automatic logic [RATE_W-1:0] abs_rate(input logic [RATE_W-1:0] v);
        logic [RATE_W-1:0] neg;
        neg = ~v + 1'b1;
        return v[RATE_W-1] ? neg : v;
    endfunction

    always_comb
    begin
        abs_in[0] = abs_rate(sample.rate_x);
        abs_in[1] = abs_rate(sample.rate_y);
        abs_in[2] = abs_rate(sample.rate_z);
    end

    // Each lane multiplies its rate by the low digit of its shifting copy.
    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            case (m_reg[j][DIGIT_W-1:0])
                2'd0:    term[j] = '0;
                2'd1:    term[j] = TERM_W'(a_reg[j]);
                2'd2:    term[j] = TERM_W'({a_reg[j], 1'b0});
                default: term[j] = TERM_W'(a3_reg[j]);
            endcase
        end
        digit_sum = term[0] + term[1] + term[2];
        upper_sum = TERM_W'(acc_reg[ACC_W-1:RATE_W]) + digit_sum;
        acc_next  = {upper_sum, acc_reg[RATE_W-1:DIGIT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                a_reg[j]  <= abs_in[j];
                a3_reg[j] <= {1'b0, abs_in[j]} + {abs_in[j], 1'b0};
                m_reg[j]  <= abs_in[j];
            end
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                m_reg[j] <= m_reg[j] >> DIGIT_W;
            end
            acc_reg <= acc_next;
        end
    end

    assign sum  = acc_reg[SUMSQ_W-1:0];
    assign done = done_reg;

endmodule

/* rtl/shk_isqrt.sv */
`timescale 1ns / 1ps
// Floor integer square root, one root bit per cycle (restoring digit method).
// Depends on shk_pkg.
module shk_isqrt
    import shk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUMSQ_W-1:0]  radicand,
    output logic [ROOT_W-1:0]   root,
    output logic                done
);

    localparam int STEPS = ROOT_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = ROOT_W + 1;
    localparam int TRY_W = REM_W + 2;

    logic [SUMSQ_W-1:0] rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [TRY_W-1:0]   partial;
    logic [TRY_W-1:0]   trial;
    logic [TRY_W-1:0]   diff;
    logic               fits;

    always_comb
    begin
        partial = {rem_reg, rad_reg[SUMSQ_W-1 -: 2]};
        trial   = TRY_W'({root_reg, 2'b01});
        diff    = partial - trial;
        fits    = (partial >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= partial[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* rtl/shake_toggle_detector.sv */
`timescale 1ns / 1ps
// Shake toggle detector: top level. Each transaction on the sample channel carries
// one signed three-axis gyro rate and produces exactly one transaction on the result
// channel. The block forms the magnitude floor(sqrt(x*x + y*y + z*z)), keeps the last
// WINDOW magnitudes in a ring (all zero after reset) together with their running
// total, and compares that total exactly against motion_cutoff * WINDOW. A total
// above the limit raises high_motion; a later total below it drops the flag and
// toggles the LED, which the result reports with toggled. A total equal to the
// limit changes nothing. window_total saturates at 2097151, which only a WINDOW
// above 36 can reach. A transaction passes from acceptance through the radix-4
// squaring unit, the bit-serial square root, the ring update and the threshold
// decision, in that order; a new sample is accepted only once the block is back
// in idle after the decision. The result sits in an output register, so the next
// sample is accepted while it waits; only a result still unaccepted when the
// following decision is ready holds the block. motion_cutoff lives at byte address
// 0 of the APB-style port and resets to 20000; the user must write it only while
// the block is idle, which the block itself does not enforce.
// Depends on shk_pkg, shk_sumsq, shk_isqrt and shk_ram.
module shake_toggle_detector
    import shk_pkg::*;
#(
    parameter int WINDOW = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_t                sample,

    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Ring pointer, internal total and limit widths all follow from WINDOW.
    localparam int PTR_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * MAG_MAX + 1);
    localparam int LIM_W = CUTOFF_W + $clog2(WINDOW + 1);
    localparam int CMP_W = (SUM_W > LIM_W) ?
                           ((SUM_W > TOTAL_W) ? SUM_W : TOTAL_W) :
                           ((LIM_W > TOTAL_W) ? LIM_W : TOTAL_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ROOT,
        S_DECIDE
    } state_t;

    state_t              state_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [LIM_W-1:0]    limit_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic [WINDOW-1:0]   vld_reg;
    logic [SUM_W-1:0]    total_reg;
    logic [SUM_W-1:0]    total_next;
    logic                flag_reg;
    logic                lamp_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic                cfg_write;
    logic                accept;
    logic                load;
    logic                root_start;
    logic [SUMSQ_W-1:0]  sumsq;
    logic                sumsq_done;
    logic [ROOT_W-1:0]   mag;
    logic                mag_done;
    logic [ROOT_W-1:0]   ring_rdata;
    logic [ROOT_W-1:0]   ring_old;
    logic [CMP_W-1:0]    total_ext;
    logic [CMP_W-1:0]    limit_ext;
    logic                above;
    logic                below;
    logic                flag_next;
    logic                lamp_next;
    logic                tog_next;
    logic [TOTAL_W-1:0]  shown;

    // Configuration port. Bits below the register index select bytes and are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[PADDR_W-1:2] == REG_MOTION_CUTOFF) ?
                       APB_DATA_W'(cutoff_reg) : '0;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign root_start   = (state_reg == S_MUL) && sumsq_done;
    assign load         = !result_valid_reg || result_ready;

    shk_sumsq u_sumsq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .sample (sample),
        .sum    (sumsq),
        .done   (sumsq_done)
    );

    shk_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sumsq),
        .root     (mag),
        .done     (mag_done)
    );

    // The ring is read continuously at the pointer; the data is settled long before
    // the root finishes, and the slot is written when the new magnitude arrives.
    shk_ram #(
        .WIDTH (ROOT_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (mag_done),
        .waddr (ptr_reg),
        .wdata (mag),
        .raddr (ptr_reg),
        .rdata (ring_rdata)
    );

    // A slot that was never written since reset counts as zero.
    always_comb
    begin
        ring_old   = vld_reg[ptr_reg] ? ring_rdata : '0;
        total_next = total_reg - SUM_W'(ring_old) + SUM_W'(mag);
        ptr_next   = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    end

    // Threshold decision on the updated total.
    always_comb
    begin
        total_ext = CMP_W'(total_reg);
        limit_ext = CMP_W'(limit_reg);
        above     = (total_ext > limit_ext);
        below     = (total_ext < limit_ext);
        flag_next = flag_reg;
        lamp_next = lamp_reg;
        tog_next  = 1'b0;
        if (flag_reg && below)
        begin
            flag_next = 1'b0;
            lamp_next = !lamp_reg;
            tog_next  = 1'b1;
        end
        else if (!flag_reg && above)
        begin
            flag_next = 1'b1;
        end
        shown = (total_ext > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : total_ext[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cutoff_reg       <= CUTOFF_RESET;
            ptr_reg          <= '0;
            vld_reg          <= '0;
            total_reg        <= '0;
            flag_reg         <= 1'b0;
            lamp_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[PADDR_W-1:2] == REG_MOTION_CUTOFF))
            begin
                cutoff_reg <= pwdata[CUTOFF_W-1:0];
            end

            // A new result replaces the one taken in the same cycle.
            if ((state_reg == S_DECIDE) && load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (sumsq_done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (mag_done)
                    begin
                        total_reg        <= total_next;
                        vld_reg[ptr_reg] <= 1'b1;
                        ptr_reg          <= ptr_next;
                        state_reg        <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (load)
                    begin
                        flag_reg  <= flag_next;
                        lamp_reg  <= lamp_next;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        limit_reg <= LIM_W'(cutoff_reg * WINDOW);
        if ((state_reg == S_DECIDE) && load)
        begin
            result_reg.magnitude    <= mag;
            result_reg.window_total <= shown;
            result_reg.high_motion  <= flag_next;
            result_reg.led_on       <= lamp_next;
            result_reg.toggled      <= tog_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The ring pointer never leaves the window.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(WINDOW - 1))
        else $error("ring pointer outside the window");

    // The running total never exceeds a full window of largest magnitudes.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= SUM_W'(WINDOW * MAG_MAX))
        else $error("running total out of range");

    // A toggle always ends the high-motion episode.
    a_toggle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.toggled && result_reg.high_motion))
        else $error("toggle reported while high motion still set");

    // The lamp changes exactly when a result reports a toggle.
    a_lamp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && load) |=>
            ((lamp_reg != $past(lamp_reg)) == result_reg.toggled))
        else $error("lamp state and toggle flag disagree");

endmodule

/* bench/tb_shake_toggle_detector.sv */
`timescale 1ns / 1ps
// Self-checking bench for shake_toggle_detector: drives gyro samples and APB writes.
// Every result is predicted by a window model kept here and checked in order.
// Depends on shk_pkg and the shake_toggle_detector RTL with its submodules.
module tb_shake_toggle_detector;
    import shk_pkg::*;

    localparam int WINDOW       = 20;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_ITEMS  = 1850;
    // The tail keeps waiting after the last result for stray transactions.
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 200;
    // The slowest legal run is about 4 ms; this allows five times that.
    localparam longint TIMEOUT_NS = 20_000_000;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED  = REG_MOTION_CUTOFF + 1'b1;
    localparam logic [PADDR_W-1:0]   CUTOFF_ADDR = {REG_MOTION_CUTOFF, 2'b00};
    localparam logic [PADDR_W-1:0]   UNUSED_ADDR = {REG_UNUSED, 2'b00};

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample       = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [PADDR_W-1:0]    paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted block state: magnitude history, its sum, the motion flag and the LED.
    logic [ROOT_W-1:0]   mag_history [WINDOW];
    int unsigned         history_slot;
    longint unsigned     history_sum;
    logic                shake_active;
    logic                lamp_lit;
    logic [CUTOFF_W-1:0] cutoff_setting;

    result_t     pending_results [$];
    result_t     oldest_expected;
    int unsigned samples_sent = 0;
    int unsigned error_count  = 0;
    int unsigned stall_left   = 0;
    // While set, neither the sample sender nor the result receiver inserts idle cycles.
    bit          steady_flow  = 1'b0;

    shake_toggle_detector #(
        .WINDOW(WINDOW)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Builds the root one bit at a time from the top, keeping a bit when the
    // trial square still fits under the energy.
    function automatic logic [ROOT_W-1:0] floor_root(longint unsigned energy);
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        longint unsigned   trial_wide;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            trial      = root | (ROOT_W'(1) << b);
            trial_wide = trial;
            if (trial_wide * trial_wide <= energy)
                root = trial;
        end
        return root;
    endfunction

    // -32768 squares to 2^30 since the sign extension keeps its full magnitude.
    function automatic longint unsigned axis_square(logic signed [RATE_W-1:0] rate);
        longint wide;
        wide = rate;
        if (wide < 0)
            wide = -wide;
        return wide * wide;
    endfunction

    // One sample through the window: replace the oldest magnitude, then compare the
    // sum exactly with cutoff * WINDOW. An equal sum leaves the flag where it is.
    function automatic result_t step_motion_model(sample_t s);
        result_t           r;
        logic [ROOT_W-1:0] mag;
        longint unsigned   limit;
        mag   = floor_root(axis_square(s.rate_x) + axis_square(s.rate_y)
                           + axis_square(s.rate_z));
        limit = cutoff_setting * WINDOW;
        history_sum               = history_sum - mag_history[history_slot] + mag;
        mag_history[history_slot] = mag;
        history_slot              = (history_slot + 1) % WINDOW;
        r = '0;
        if (shake_active && history_sum < limit)
        begin
            shake_active = 1'b0;
            lamp_lit     = ~lamp_lit;
            r.toggled    = 1'b1;
        end
        else if (!shake_active && history_sum > limit)
        begin
            shake_active = 1'b1;
        end
        r.magnitude    = mag;
        r.window_total = (history_sum > TOTAL_MAX) ? TOTAL_MAX : history_sum[TOTAL_W-1:0];
        r.high_motion  = shake_active;
        r.led_on       = lamp_lit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void compare_field(string what, longint unsigned expected,
                                          longint unsigned actual);
        if (expected != actual)
        begin
            error_count++;
            // Past a couple hundred reports a broken block only floods the log.
            if (error_count <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, expected, actual);
        end
    endfunction

    // Outputs are sampled at the rising edge, before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result transaction, expected none, actual %p",
                             $time, result);
            end
            else
            begin
                oldest_expected = pending_results.pop_front();
                compare_field("magnitude", oldest_expected.magnitude, result.magnitude);
                compare_field("window_total", oldest_expected.window_total,
                              result.window_total);
                compare_field("high_motion", oldest_expected.high_motion, result.high_motion);
                compare_field("led_on", oldest_expected.led_on, result.led_on);
                compare_field("toggled", oldest_expected.toggled, result.toggled);
            end
        end
    end

    // Receiver back-pressure comes in runs of random length, so a finished result
    // sometimes waits in the output register while the next sample is already in work.
    // Together the runs hold ready low roughly a fifth of the time.
    always @(negedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else if (!steady_flow && $urandom_range(0, 999) < 13)
            stall_left = $urandom_range(1, 36);
        result_ready <= (stall_left == 0);
    end

    // ------------------------------------------------------------------
    // Sample channel
    // ------------------------------------------------------------------

    // Valid stays high after acceptance, so the caller's next step must start at the
    // following falling edge with either another send or hold_samples. Random gaps
    // can outlast one computation, so they land on every phase of it.
    task automatic send_sample(sample_t s);
        if (!steady_flow && $urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 40))
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
            end
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        sample       <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_results.push_back(step_motion_model(s));
        samples_sent++;
    endtask

    task automatic send_rates(int x, int y, int z);
        sample_t s;
        s.rate_x = RATE_W'(x);
        s.rate_y = RATE_W'(y);
        s.rate_z = RATE_W'(z);
        send_sample(s);
    endtask

    task automatic hold_samples;
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    // Every sample yields a result, so the block is idle once the last one is taken.
    task automatic wait_drained;
        hold_samples();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        // Only the cutoff register decodes; anything else is dropped by the block.
        if (addr[PADDR_W-1:2] == REG_MOTION_CUTOFF)
            cutoff_setting = data[CUTOFF_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_cutoff_readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CUTOFF_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        compare_field("motion_cutoff readback", cutoff_setting, prdata[CUTOFF_W-1:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are random; the register keeps only its low 16 bits.
    task automatic set_cutoff(logic [CUTOFF_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word                 = $urandom();
        word[CUTOFF_W-1:0]   = value;
        wait_drained();
        apb_write(CUTOFF_ADDR, word);
        check_cutoff_readback();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // From the cleared window: a sum equal to the limit must neither raise nor
    // drop the flag, one step above raises it, one step below drops it and
    // toggles the LED. The cutoff is moved between samples to land on each case.
    task automatic test_threshold_edges;
        check_cutoff_readback();
        set_cutoff(16'd2000);
        send_rates(-24000, 32000, 0);   // magnitude 40000, sum equals the limit
        send_rates(0, 0, 20);           // sum 40020, now above
        set_cutoff(16'd2001);
        send_rates(0, 0, 0);            // sum 40020 equals the new limit, flag holds
        set_cutoff(16'd2002);
        send_rates(0, 0, 0);            // sum below the limit, flag drops, LED on
    endtask

    // Most negative and most positive rates on every axis, with the cutoff at both
    // ends of its range, and a write to an address that holds no register.
    task automatic test_field_extremes;
        set_cutoff(16'd0);
        send_rates(-32768, -32768, -32768);
        send_rates(32767, 32767, 32767);
        send_rates(0, 0, 0);
        send_rates(-1, -1, -1);
        set_cutoff(16'hFFFF);
        send_rates(-32768, 0, 0);
        send_rates(0, 32767, 0);
        send_rates(0, 0, -32768);
        send_rates(1, -32768, 32767);
        wait_drained();
        apb_write(UNUSED_ADDR, 32'h0000_1234);
        check_cutoff_readback();
        send_rates(-1, 0, 1);
    endtask

    function automatic int corner_rate();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    // A run of samples of one character. Calm and shake runs alternate at random, so
    // the windowed average keeps crossing the cutoff both ways; plateau runs hold the
    // magnitude at the cutoff (or one off it) so the sum sits right on the limit.
    task automatic send_motion_burst;
        sample_t     s;
        int unsigned kind;
        int unsigned swing;
        int          level;
        int          axis_value;
        kind  = $urandom_range(0, 99);
        swing = $urandom_range(0, 3000);
        level = int'(cutoff_setting) + int'($urandom_range(0, 2)) - 1;
        if (level < 0)
            level = 0;
        if (level > 32767)
            level = 32767;
        repeat ($urandom_range(3, 40))
        begin
            s = '0;
            if (kind < 30)
            begin
                s.rate_x = RATE_W'(int'($urandom_range(0, 2 * swing)) - int'(swing));
                s.rate_y = RATE_W'(int'($urandom_range(0, 2 * swing)) - int'(swing));
                s.rate_z = RATE_W'(int'($urandom_range(0, 2 * swing)) - int'(swing));
            end
            else if (kind < 65)
            begin
                s.rate_x = RATE_W'($urandom());
                s.rate_y = RATE_W'($urandom());
                s.rate_z = RATE_W'($urandom());
            end
            else if (kind < 80)
            begin
                axis_value = $urandom_range(0, 1) ? level : -level;
                case ($urandom_range(0, 2))
                    0:       s.rate_x = RATE_W'(axis_value);
                    1:       s.rate_y = RATE_W'(axis_value);
                    default: s.rate_z = RATE_W'(axis_value);
                endcase
            end
            else if (kind < 90)
            begin
                s.rate_x = RATE_W'(corner_rate());
                s.rate_y = RATE_W'(corner_rate());
                s.rate_z = RATE_W'(corner_rate());
            end
            else
            begin
                // Noise: each axis independently quiet or wild.
                s.rate_x = $urandom_range(0, 1) ? RATE_W'($urandom()) : RATE_W'(swing);
                s.rate_y = $urandom_range(0, 1) ? RATE_W'($urandom()) : -RATE_W'(swing);
                s.rate_z = $urandom_range(0, 1) ? RATE_W'($urandom()) : RATE_W'(0);
            end
            send_sample(s);
        end
    endtask

    // Phases of 100 to 289 samples (the last may stop short), each under a fresh
    // cutoff. Most cutoffs fall where calm and shake runs straddle them; some sit at
    // the ends of the range. The fourth phase runs with no idle cycles on either side.
    task automatic test_random_motion;
        int unsigned phase;
        int unsigned phase_end;
        phase = 0;
        while (samples_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       set_cutoff(16'd0);
                1:       set_cutoff(16'hFFFF);
                2:       set_cutoff(CUTOFF_W'($urandom()));
                default: set_cutoff(CUTOFF_W'($urandom_range(1500, 30000)));
            endcase
            steady_flow = (phase == 3);
            phase_end   = samples_sent + $urandom_range(100, 250);
            while (samples_sent < phase_end && samples_sent < TOTAL_ITEMS)
                send_motion_burst();
            phase++;
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        foreach (mag_history[i])
            mag_history[i] = '0;
        history_slot   = 0;
        history_sum    = 0;
        shake_active   = 1'b0;
        lamp_lit       = 1'b0;
        cutoff_setting = CUTOFF_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_threshold_edges();
        test_field_extremes();
        test_random_motion();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
